/* rtl/linear_diophantine_range_count_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers. They expect clk and rst_n in the using scope.
// ---------------------------------------------------------------------------
`ifndef LINEAR_DIOPHANTINE_RANGE_COUNT_MACROS_SVH
`define LINEAR_DIOPHANTINE_RANGE_COUNT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define LDRC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ldrc assertion failed");

// same-cycle implication
`define LDRC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ldrc assertion failed");

// next-cycle implication
`define LDRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ldrc assertion failed");

`else

`define LDRC_ASSERT(lbl, cond)
`define LDRC_ASSERT_IMPL(lbl, ante, cons)
`define LDRC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/ldrc_pkg.sv */
// ---------------------------------------------------------------------------
// ldrc_pkg
// Shared types for the Diophantine range counter: result codes, datapath
// operations, controller states and the command/status bundles.
// ---------------------------------------------------------------------------
package ldrc_pkg;

  typedef enum logic [1:0] {
    STATUS_COUNTED     = 2'd0,
    STATUS_NO_SOLUTION = 2'd1,
    STATUS_ZERO_COEF   = 2'd2
  } status_t;

  // one datapath micro-operation per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_EU_DIV,
    OP_EU_Q,
    OP_EU_STEP,
    OP_GCD,
    OP_CG,
    OP_BP,
    OP_AP,
    OP_XR,
    OP_CM,
    OP_X0M,
    OP_X0,
    OP_LW,
    OP_UW,
    OP_ORIENT,
    OP_XL,
    OP_XH,
    OP_CNT_ZERO,
    OP_F1,
    OP_F1W,
    OP_F2W
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_EU_TEST,
    S_EU_DIV_W,
    S_EU_MUL_W,
    S_GCD_W,
    S_BP_W,
    S_AP_W,
    S_XR_W,
    S_CM_W,
    S_X0M_W,
    S_X0_W,
    S_LW_W,
    S_UW_W,
    S_ORIENT,
    S_XL_W,
    S_XH_W,
    S_CNT_CHK,
    S_F1_W,
    S_F2_W,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t  op;
    logic    out_load;
    status_t out_status;
  } ldrc_cmd_t;

  typedef struct packed {
    logic zero_coef;
    logic r1_zero;
    logic div_done;
    logic mul_done;
    logic div_rem_nz;
    logic range_empty;
  } ldrc_sts_t;

endpackage

/* rtl/ldrc_div.sv */
// ---------------------------------------------------------------------------
// ldrc_div
// Restoring unsigned divider, one quotient bit per cycle. Short mode runs
// only over the low SW numerator bits.
// ---------------------------------------------------------------------------
`include "linear_diophantine_range_count_macros.svh"

module ldrc_div #(
  parameter int NW = 68,
  parameter int SW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          short_mode,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [NW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [NW-1:0] num_r;
  logic [NW-1:0] den_r;
  logic [NW-1:0] quot_r;
  logic [NW-1:0] rem_r;
  logic [NW:0]   trial;
  logic [NW:0]   diff;
  logic          take;

  assign trial = {rem_r, num_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign take  = ~diff[NW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= short_mode ? CW'(SW) : CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= short_mode ? (num << (NW - SW)) : num;
      den_r  <= den;
      quot_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      num_r  <= num_r << 1;
      rem_r  <= take ? diff[NW-1:0] : trial[NW-1:0];
      quot_r <= {quot_r[NW-2:0], take};
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

  `LDRC_ASSERT_IMPL(a_div_no_restart, start, !busy_r)
  `LDRC_ASSERT_NEXT(a_div_done_pulse, done_r, !done_r)
  `LDRC_ASSERT_IMPL(a_div_cnt_live, busy_r, cnt_r != '0)

endmodule

/* rtl/ldrc_mul.sv */
// ---------------------------------------------------------------------------
// ldrc_mul
// Shift-add unsigned multiplier; stops as soon as the multiplier runs out
// of set bits.
// ---------------------------------------------------------------------------
module ldrc_mul #(
  parameter int NW = 68
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] a,
  input  logic [NW-1:0] b,
  output logic          done,
  output logic [NW-1:0] prod
);

  logic          busy_r;
  logic          done_r;
  logic [NW-1:0] a_r;
  logic [NW-1:0] b_r;
  logic [NW-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (b_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r && (b_r != '0)) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

/* rtl/ldrc_dp.sv */
// ---------------------------------------------------------------------------
// ldrc_dp
// Datapath: operand and intermediate registers, the shared divider and
// multiplier, and the result registers. Driven one op per cycle.
// ---------------------------------------------------------------------------
module ldrc_dp #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic signed [W-1:0]  in_coef_a,
  input  logic signed [W-1:0]  in_coef_b,
  input  logic signed [W-1:0]  in_target_c,
  input  logic signed [W-1:0]  in_x_low,
  input  logic signed [W-1:0]  in_x_high,
  input  logic signed [W-1:0]  in_y_low,
  input  logic signed [W-1:0]  in_y_high,
  input  ldrc_pkg::ldrc_cmd_t  cmd,
  output ldrc_pkg::ldrc_sts_t  sts,
  output logic [W:0]           out_solution_count,
  output ldrc_pkg::status_t    out_status
);

  import ldrc_pkg::*;

  // headroom for c - (b/g)*y and for signed intermediates
  localparam int NW = 2 * W + 4;

  typedef logic signed [NW-1:0] sw_t;

  localparam sw_t ONE = sw_t'(1);

  function automatic sw_t sext(input logic [W-1:0] v);
    return {{(NW - W){v[W-1]}}, v};
  endfunction

  function automatic logic [NW-1:0] mag(input sw_t v);
    return v[NW-1] ? -v : v;
  endfunction

  sw_t a_r, b_r, c_r, xlo_r, xhi_r, ylo_r, yhi_r;
  sw_t r0_r, r1_r, s0_r, s1_r;
  sw_t cg_r, bp_r, ap_r, xr_r, x0_r;
  sw_t lw_r, uw_r, p_r, xl_r, xh_r, f1_r, cnt_r;
  logic num_neg_r;
  logic ysgn_r;
  logic [W:0] out_count_r;
  status_t    out_status_r;

  logic          div_start, div_short, div_done;
  logic [NW-1:0] div_num, div_den, div_q, div_r;
  logic          mul_start, mul_done;
  logic [NW-1:0] mul_a, mul_b, mul_p;

  sw_t q_s, r_s, rnz_w, fmod, flr, cel, prod_s;
  sw_t s0a, ya, yb, lw_n, uw_n, p_n, d1, d2, ts, byprod;
  sw_t xl_t, xh_t;
  logic ap_neg;

  assign q_s    = $signed(div_q);
  assign r_s    = $signed(div_r);
  assign rnz_w  = (div_r != '0) ? ONE : '0;
  // floor mod, floor and ceiling of the last signed division
  assign fmod   = (num_neg_r && (div_r != '0)) ? bp_r - r_s : r_s;
  assign flr    = num_neg_r ? -q_s - rnz_w : q_s;
  assign cel    = num_neg_r ? -q_s : q_s + rnz_w;
  assign prod_s = $signed(mul_p);

  assign s0a    = a_r[NW-1] ? -s0_r : s0_r;
  assign ya     = b_r[NW-1] ? ylo_r : yhi_r;
  assign yb     = b_r[NW-1] ? yhi_r : ylo_r;
  assign byprod = (b_r[NW-1] ^ ysgn_r) ? -prod_s : prod_s;
  assign ts     = s0_r - (s1_r[NW-1] ? -prod_s : prod_s);

  assign ap_neg = ap_r[NW-1];
  assign lw_n   = ap_neg ? -uw_r : lw_r;
  assign uw_n   = ap_neg ? -lw_r : uw_r;
  assign p_n    = ap_neg ? -ap_r : ap_r;

  assign d1     = xh_r - x0_r;
  assign d2     = xl_r - ONE - x0_r;

  // x range clip: lower bound never below x_low, upper never above x_high
  always_comb begin
    xl_t = (cel > xhi_r + ONE) ? xhi_r + ONE : cel;
    if (xl_t < xlo_r) begin
      xl_t = xlo_r;
    end
    xh_t = (flr < xlo_r - ONE) ? xlo_r - ONE : flr;
    if (xh_t > xhi_r) begin
      xh_t = xhi_r;
    end
  end

  // unit launches
  always_comb begin
    div_start = 1'b0;
    div_short = 1'b0;
    div_num   = '0;
    div_den   = '0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (cmd.op)
      OP_EU_DIV: begin
        div_start = 1'b1;
        div_short = 1'b1;
        div_num   = mag(r0_r);
        div_den   = mag(r1_r);
      end
      OP_EU_Q: begin
        mul_start = 1'b1;
        mul_a     = mag(s1_r);
        mul_b     = div_q;
      end
      OP_GCD: begin
        div_start = 1'b1;
        div_short = 1'b1;
        div_num   = mag(c_r);
        div_den   = mag(r0_r);
      end
      OP_CG: begin
        div_start = 1'b1;
        div_short = 1'b1;
        div_num   = mag(b_r);
        div_den   = mag(r0_r);
      end
      OP_BP: begin
        div_start = 1'b1;
        div_short = 1'b1;
        div_num   = mag(a_r);
        div_den   = mag(r0_r);
      end
      OP_AP: begin
        div_start = 1'b1;
        div_num   = mag(s0a);
        div_den   = mag(bp_r);
      end
      OP_XR: begin
        div_start = 1'b1;
        div_short = 1'b1;
        div_num   = mag(cg_r);
        div_den   = mag(bp_r);
      end
      OP_CM: begin
        mul_start = 1'b1;
        mul_a     = mag(xr_r);
        mul_b     = mag(fmod);
      end
      OP_X0M: begin
        div_start = 1'b1;
        div_num   = mul_p;
        div_den   = mag(bp_r);
      end
      OP_X0: begin
        mul_start = 1'b1;
        mul_a     = mag(bp_r);
        mul_b     = mag(ya);
      end
      OP_LW: begin
        mul_start = 1'b1;
        mul_a     = mag(bp_r);
        mul_b     = mag(yb);
      end
      OP_ORIENT: begin
        div_start = 1'b1;
        div_num   = mag(lw_n);
        div_den   = mag(p_n);
      end
      OP_XL: begin
        div_start = 1'b1;
        div_num   = mag(uw_r);
        div_den   = mag(p_r);
      end
      OP_F1: begin
        div_start = 1'b1;
        div_num   = mag(d1);
        div_den   = mag(bp_r);
      end
      OP_F1W: begin
        div_start = 1'b1;
        div_num   = mag(d2);
        div_den   = mag(bp_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        a_r   <= sext(in_coef_a);
        b_r   <= sext(in_coef_b);
        c_r   <= sext(in_target_c);
        xlo_r <= sext(in_x_low);
        xhi_r <= sext(in_x_high);
        ylo_r <= sext(in_y_low);
        yhi_r <= sext(in_y_high);
        r0_r  <= $signed(mag(sext(in_coef_a)));
        r1_r  <= $signed(mag(sext(in_coef_b)));
        s0_r  <= ONE;
        s1_r  <= '0;
      end
      OP_EU_STEP: begin
        r0_r <= r1_r;
        r1_r <= r_s;
        s0_r <= s1_r;
        s1_r <= ts;
      end
      OP_CG: begin
        cg_r <= c_r[NW-1] ? -q_s : q_s;
      end
      OP_BP: begin
        bp_r <= q_s;
      end
      OP_AP: begin
        ap_r      <= a_r[NW-1] ? -q_s : q_s;
        num_neg_r <= s0a[NW-1];
      end
      OP_XR: begin
        xr_r      <= fmod;
        num_neg_r <= cg_r[NW-1];
      end
      OP_X0: begin
        x0_r   <= r_s;
        ysgn_r <= ya[NW-1];
      end
      OP_LW: begin
        lw_r   <= cg_r - byprod;
        ysgn_r <= yb[NW-1];
      end
      OP_UW: begin
        uw_r <= cg_r - byprod;
      end
      OP_ORIENT: begin
        lw_r      <= lw_n;
        uw_r      <= uw_n;
        p_r       <= p_n;
        num_neg_r <= lw_n[NW-1];
      end
      OP_XL: begin
        xl_r      <= xl_t;
        num_neg_r <= uw_r[NW-1];
      end
      OP_XH: begin
        xh_r <= xh_t;
      end
      OP_CNT_ZERO: begin
        cnt_r <= '0;
      end
      OP_F1: begin
        num_neg_r <= d1[NW-1];
      end
      OP_F1W: begin
        f1_r      <= flr;
        num_neg_r <= d2[NW-1];
      end
      OP_F2W: begin
        cnt_r <= f1_r - flr;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_count_r  <= (cmd.out_status == STATUS_COUNTED) ? cnt_r[W:0] : '0;
    end
  end

  ldrc_div #(
    .NW (NW),
    .SW (W)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .short_mode (div_short),
    .num        (div_num),
    .den        (div_den),
    .done       (div_done),
    .quot       (div_q),
    .rem        (div_r)
  );

  ldrc_mul #(
    .NW (NW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  assign sts.zero_coef   = (a_r == '0) || (b_r == '0);
  assign sts.r1_zero     = (r1_r == '0);
  assign sts.div_done    = div_done;
  assign sts.mul_done    = mul_done;
  assign sts.div_rem_nz  = (div_r != '0);
  assign sts.range_empty = (xl_r > xh_r);

  assign out_solution_count = out_count_r;
  assign out_status         = out_status_r;

endmodule

/* rtl/ldrc_ctrl.sv */
// ---------------------------------------------------------------------------
// ldrc_ctrl
// Sequencer: walks one item through Euclid, the clipping steps and the
// final count, and owns both handshakes.
// ---------------------------------------------------------------------------
`include "linear_diophantine_range_count_macros.svh"

module ldrc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output ldrc_pkg::ldrc_cmd_t cmd,
  input  ldrc_pkg::ldrc_sts_t sts
);

  import ldrc_pkg::*;

  ctrl_state_t state_r, state_nxt;
  status_t     status_r, status_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= STATUS_COUNTED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd.op         = OP_NONE;
    cmd.out_load   = 1'b0;
    cmd.out_status = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.zero_coef) begin
          status_nxt = STATUS_ZERO_COEF;
          state_nxt  = S_FINISH;
        end else begin
          state_nxt = S_EU_TEST;
        end
      end
      S_EU_TEST: begin
        if (sts.r1_zero) begin
          cmd.op    = OP_GCD;
          state_nxt = S_GCD_W;
        end else begin
          cmd.op    = OP_EU_DIV;
          state_nxt = S_EU_DIV_W;
        end
      end
      S_EU_DIV_W: begin
        if (sts.div_done) begin
          cmd.op    = OP_EU_Q;
          state_nxt = S_EU_MUL_W;
        end
      end
      S_EU_MUL_W: begin
        if (sts.mul_done) begin
          cmd.op    = OP_EU_STEP;
          state_nxt = S_EU_TEST;
        end
      end
      S_GCD_W: begin
        if (sts.div_done) begin
          if (sts.div_rem_nz) begin
            status_nxt = STATUS_NO_SOLUTION;
            state_nxt  = S_FINISH;
          end else begin
            cmd.op    = OP_CG;
            state_nxt = S_BP_W;
          end
        end
      end
      S_BP_W: begin
        if (sts.div_done) begin
          cmd.op    = OP_BP;
          state_nxt = S_AP_W;
        end
      end
      S_AP_W: begin
        if (sts.div_done) begin
          cmd.op    = OP_AP;
          state_nxt = S_XR_W;
        end
      end
      S_XR_W: begin
        if (sts.div_done) begin
          cmd.op    = OP_XR;
          state_nxt = S_CM_W;
        end
      end
      S_CM_W: begin
        if (sts.div_done) begin
          cmd.op    = OP_CM;
          state_nxt = S_X0M_W;
        end
      end
      S_X0M_W: begin
        if (sts.mul_done) begin
          cmd.op    = OP_X0M;
          state_nxt = S_X0_W;
        end
      end
      S_X0_W: begin
        if (sts.div_done) begin
          cmd.op    = OP_X0;
          state_nxt = S_LW_W;
        end
      end
      S_LW_W: begin
        if (sts.mul_done) begin
          cmd.op    = OP_LW;
          state_nxt = S_UW_W;
        end
      end
      S_UW_W: begin
        if (sts.mul_done) begin
          cmd.op    = OP_UW;
          state_nxt = S_ORIENT;
        end
      end
      S_ORIENT: begin
        cmd.op    = OP_ORIENT;
        state_nxt = S_XL_W;
      end
      S_XL_W: begin
        if (sts.div_done) begin
          cmd.op    = OP_XL;
          state_nxt = S_XH_W;
        end
      end
      S_XH_W: begin
        if (sts.div_done) begin
          cmd.op    = OP_XH;
          state_nxt = S_CNT_CHK;
        end
      end
      S_CNT_CHK: begin
        status_nxt = STATUS_COUNTED;
        if (sts.range_empty) begin
          cmd.op    = OP_CNT_ZERO;
          state_nxt = S_FINISH;
        end else begin
          cmd.op    = OP_F1;
          state_nxt = S_F1_W;
        end
      end
      S_F1_W: begin
        if (sts.div_done) begin
          cmd.op    = OP_F1W;
          state_nxt = S_F2_W;
        end
      end
      S_F2_W: begin
        if (sts.div_done) begin
          cmd.op    = OP_F2W;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign out_valid = out_valid_r;

  `LDRC_ASSERT(a_units_exclusive, !(sts.div_done && sts.mul_done))
  `LDRC_ASSERT_IMPL(a_out_from_finish, $rose(out_valid_r), $past(state_r) == S_FINISH)
  `LDRC_ASSERT_NEXT(a_accept_to_check, in_valid && !in_stall, state_r == S_CHECK)

endmodule

/* rtl/linear_diophantine_range_count.sv */
// ---------------------------------------------------------------------------
// linear_diophantine_range_count
// Counts integer (x, y) in an inclusive box that solve a*x + b*y = c.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one beat carries a, b, c and the box.
// A beat is taken only while the sequencer is idle; in_stall is high for
// the whole time an item is being worked on.
// Result channel (out_valid / out_stall): one beat per input, carrying the
// count and a status (counted, no integer solution, zero coefficient).
// The result sits in an output register, so a new input is taken while the
// previous result still waits for the receiver. A finished item waits in
// its last state while out_stall holds the older result.
// Steps: a zero coefficient skips all arithmetic. Otherwise
// extended Euclid runs on one shared divider (W = OPERAND_WIDTH) plus
// a shift-add multiply per step, up to about 1.44*W steps; the rest
// then takes four short and six full-width divisions and three
// multiplies.
// Reset (rst_n, synchronous, active low) idles the sequencer and drops
// out_valid; no memories need clearing.
// ---------------------------------------------------------------------------
module linear_diophantine_range_count #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [OPERAND_WIDTH-1:0] in_coef_a,
  input  logic signed [OPERAND_WIDTH-1:0] in_coef_b,
  input  logic signed [OPERAND_WIDTH-1:0] in_target_c,
  input  logic signed [OPERAND_WIDTH-1:0] in_x_low,
  input  logic signed [OPERAND_WIDTH-1:0] in_x_high,
  input  logic signed [OPERAND_WIDTH-1:0] in_y_low,
  input  logic signed [OPERAND_WIDTH-1:0] in_y_high,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [OPERAND_WIDTH:0]          out_solution_count,
  output ldrc_pkg::status_t               out_status
);

  import ldrc_pkg::*;

  ldrc_cmd_t cmd;
  ldrc_sts_t sts;

  // sequencer: handshakes and step order
  ldrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: operand registers, divider, multiplier, result registers
  ldrc_dp #(
    .W (OPERAND_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_coef_a          (in_coef_a),
    .in_coef_b          (in_coef_b),
    .in_target_c        (in_target_c),
    .in_x_low           (in_x_low),
    .in_x_high          (in_x_high),
    .in_y_low           (in_y_low),
    .in_y_high          (in_y_high),
    .cmd                (cmd),
    .sts                (sts),
    .out_solution_count (out_solution_count),
    .out_status         (out_status)
  );

endmodule

/* bench/testbench.sv */
// ---------------------------------------------------------------------------
// Diophantine range counter testbench
// Drives coefficient/box beats from a queue, predicts each count and status
// with a wide-integer model kept inside the bench, and checks every result
// beat in order. Random gaps on both sides, plus one long output hold-off.
// ---------------------------------------------------------------------------
module testbench;
  import ldrc_pkg::*;

  localparam int W = 32;
  localparam longint MINV = -(64'sd1 <<< (W - 1));
  localparam longint MAXV = (64'sd1 <<< (W - 1)) - 1;

  typedef logic signed [127:0] wint_t;

  typedef struct {
    logic signed [W-1:0] a, b, c, xlo, xhi, ylo, yhi;
  } eqn_t;

  typedef struct {
    logic [W:0] cnt;
    status_t    st;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [W-1:0] in_coef_a = '0, in_coef_b = '0, in_target_c = '0;
  logic signed [W-1:0] in_x_low = '0, in_x_high = '0, in_y_low = '0, in_y_high = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [W:0] out_solution_count;
  status_t out_status;

  eqn_t    pending_eqns[$];
  answer_t expected_answers[$];
  int      errors = 0;
  int      accepted = 0;
  int      in_gap = 0;
  int      out_gap = 0;
  logic    hold_out = 1'b0;
  logic    stim_done = 1'b0;

  linear_diophantine_range_count #(.OPERAND_WIDTH(W)) u_top (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_coef_a, .in_coef_b, .in_target_c,
    .in_x_low, .in_x_high, .in_y_low, .in_y_high,
    .out_valid, .out_stall, .out_solution_count, .out_status
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly short gaps, a few long; every other 40-beat stretch runs flat out
  function automatic int pick_gap(int n);
    if ((n / 40) % 2 == 1) return 0;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(20, 90);
  endfunction

  // floor(n / d) for d > 0, clamped to [lo, hi]
  function automatic longint clip_floor(wint_t n, longint d, longint lo, longint hi);
    logic  neg;
    wint_t m, q, r;
    longint v;
    neg = n < 0;
    m = neg ? -n : n;
    q = m / d;
    r = m % d;
    if (q > (wint_t'(1) <<< 62)) return neg ? lo : hi;
    v = longint'(q);
    if (neg) v = -v - ((r != 0) ? 1 : 0);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if (n % d != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic answer_t count_solutions(eqn_t e);
    answer_t ans;
    longint a, b, c, xlo, xhi, ylo, yhi;
    longint r0, r1, s0, s1, q, t, g, bp, ap, bs, cg, xr, cm, x0, p, xl, xh, cnt;
    wint_t lw, uw, tmp;
    a = longint'(e.a); b = longint'(e.b); c = longint'(e.c);
    xlo = longint'(e.xlo); xhi = longint'(e.xhi);
    ylo = longint'(e.ylo); yhi = longint'(e.yhi);
    ans.cnt = '0;
    if (a == 0 || b == 0) begin
      ans.st = STATUS_ZERO_COEF;
      return ans;
    end
    r0 = (a < 0) ? -a : a;
    r1 = (b < 0) ? -b : b;
    s0 = 1; s1 = 0;
    while (r1 != 0) begin
      q = r0 / r1;
      t = r0 - q * r1; r0 = r1; r1 = t;
      t = s0 - q * s1; s0 = s1; s1 = t;
    end
    g = r0;
    if (c % g != 0) begin
      ans.st = STATUS_NO_SOLUTION;
      return ans;
    end
    bp = ((b < 0) ? -b : b) / g;
    ap = a / g;
    bs = b / g;
    cg = c / g;
    xr = ((a < 0) ? -s0 : s0) % bp;
    if (xr < 0) xr += bp;
    cm = cg % bp;
    if (cm < 0) cm += bp;
    x0 = longint'((wint_t'(xr) * wint_t'(cm)) % wint_t'(bp));
    // y bounds turned into L <= ap*x <= U
    if (bs > 0) begin
      lw = wint_t'(cg) - wint_t'(bs) * wint_t'(yhi);
      uw = wint_t'(cg) - wint_t'(bs) * wint_t'(ylo);
    end else begin
      lw = wint_t'(cg) - wint_t'(bs) * wint_t'(ylo);
      uw = wint_t'(cg) - wint_t'(bs) * wint_t'(yhi);
    end
    if (ap < 0) begin
      tmp = lw; lw = -uw; uw = -tmp; p = -ap;
    end else begin
      p = ap;
    end
    xl = -clip_floor(-lw, p, -(xhi + 1), -(xlo - 1));
    xh = clip_floor(uw, p, xlo - 1, xhi + 1);
    if (xl < xlo) xl = xlo;
    if (xh > xhi) xh = xhi;
    cnt = 0;
    if (xl <= xh) cnt = floor_quot(xh - x0, bp) - floor_quot(xl - 1 - x0, bp);
    ans.cnt = cnt[W:0];
    ans.st = STATUS_COUNTED;
    return ans;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: an accepted beat is predicted from the port values it carried,
  // then the next pending equation (or idle) is put up in the same edge.
  always @(posedge clk) begin
    eqn_t e;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        e.a = in_coef_a; e.b = in_coef_b; e.c = in_target_c;
        e.xlo = in_x_low; e.xhi = in_x_high; e.ylo = in_y_low; e.yhi = in_y_high;
        expected_answers.insert(expected_answers.size(), count_solutions(e));
        accepted++;
        in_gap = pick_gap(accepted);
      end
      if (in_gap > 0 || pending_eqns.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid <= 1'b0;
      end else begin
        e = pending_eqns.pop_front();
        in_valid <= 1'b1;
        in_coef_a <= e.a; in_coef_b <= e.b; in_target_c <= e.c;
        in_x_low <= e.xlo; in_x_high <= e.xhi; in_y_low <= e.ylo; in_y_high <= e.yhi;
      end
    end
  end

  // Monitor: check the result beat, then pick the next stall value.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected beat, count", out_solution_count, -1);
      end else begin
        want = expected_answers.pop_front();
        if (out_solution_count !== want.cnt)
          report_mismatch("solution_count", out_solution_count, want.cnt);
        if (out_status !== want.st)
          report_mismatch("status", out_status, want.st);
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (hold_out) begin
      out_stall <= 1'b1;
    end else begin
      out_gap = ($urandom_range(0, 3) == 0) ? pick_gap(accepted + 40) : 0;
      out_stall <= out_gap > 0;
    end
  end

  // Long receiver hold-off so that a finished item backs up behind the
  // output register and the input side stays stalled.
  initial begin
    int n;
    wait (accepted >= 60);
    @(posedge clk) hold_out <= 1'b1;
    for (n = 0; n < 7000; n++) @(posedge clk);
    hold_out <= 1'b0;
  end

  function automatic logic signed [W-1:0] any_word();
    return $urandom;
  endfunction

  function automatic logic signed [W-1:0] small_word(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic queue_eqn(longint a, longint b, longint c,
                           longint xlo, longint xhi, longint ylo, longint yhi);
    eqn_t e;
    e.a = W'(a); e.b = W'(b); e.c = W'(c);
    e.xlo = W'(xlo); e.xhi = W'(xhi); e.ylo = W'(ylo); e.yhi = W'(yhi);
    pending_eqns.insert(pending_eqns.size(), e);
  endtask

  initial begin
    eqn_t e;
    int k, span;
    // directed: zero coefficients
    queue_eqn(0, 5, 10, -10, 10, -10, 10);
    queue_eqn(7, 0, 14, -10, 10, -10, 10);
    queue_eqn(0, 0, 0, MINV, MAXV, MINV, MAXV);
    // no integer solution
    queue_eqn(4, 6, 5, -100, 100, -100, 100);
    queue_eqn(MINV, MINV, 1, MINV, MAXV, MINV, MAXV);
    // empty and inverted boxes
    queue_eqn(3, 5, 7, 10, 9, -100, 100);
    queue_eqn(3, 5, 7, -100, 100, 4, -4);
    // ordinary counts, all sign mixes
    queue_eqn(3, 5, 7, -100, 100, -100, 100);
    queue_eqn(-3, 5, 7, -100, 100, -100, 100);
    queue_eqn(3, -5, -7, -100, 100, -100, 100);
    queue_eqn(-3, -5, 7, -100, 100, -100, 100);
    queue_eqn(6, 9, 12, -50, 50, -50, 50);
    // full box, maximal counts
    queue_eqn(1, 1, 0, MINV, MAXV, MINV, MAXV);
    queue_eqn(1, -1, 0, MINV, MAXV, MINV, MAXV);
    queue_eqn(-1, 1, -1, MINV, MAXV, MINV, MAXV);
    // extreme coefficients and targets
    queue_eqn(MINV, MAXV, MAXV, MINV, MAXV, MINV, MAXV);
    queue_eqn(MAXV, MINV, MINV, MINV, MAXV, MINV, MAXV);
    queue_eqn(MINV, 2, MINV, MINV, MAXV, MINV, MAXV);
    queue_eqn(MAXV, MAXV - 1, MINV, MINV, MAXV, MINV, MAXV);
    queue_eqn(MINV, MINV, MINV, MINV, MAXV, MINV, MAXV);
    queue_eqn(1, MAXV, MAXV, 0, 0, MINV, MAXV);
    queue_eqn(2, 3, 0, 0, 0, 0, 0);
    // random: mostly small coefficients over mixed boxes, some full-width
    for (k = 0; k < 300; k++) begin
      span = (k % 3 == 0) ? 0 : ((k % 3 == 1) ? 1000 : 30);
      if (span == 0) begin
        e.a = any_word(); e.b = any_word(); e.c = any_word();
      end else begin
        e.a = small_word(span); e.b = small_word(span); e.c = small_word(span * 20);
      end
      if ($urandom_range(0, 19) == 0) e.a = 0;
      if ($urandom_range(0, 19) == 0) e.b = 0;
      if ($urandom_range(0, 1) == 0) begin
        e.xlo = any_word(); e.xhi = any_word(); e.ylo = any_word(); e.yhi = any_word();
      end else begin
        e.xlo = small_word(500); e.xhi = e.xlo + $urandom_range(0, 1000) - 20;
        e.ylo = small_word(500); e.yhi = e.ylo + $urandom_range(0, 1000) - 20;
      end
      pending_eqns.insert(pending_eqns.size(), e);
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_eqns.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    wait (expected_answers.size() == 0);
    // nothing stray may follow the last result
    repeat (200) @(posedge clk);
    if (errors == 0) $display("linear_diophantine_range_count regression: pass");
    else $display("linear_diophantine_range_count regression: fail");
    $finish;
  end

  // worst-case item time plus gaps and stalls, taken several times
  initial begin
    #(12 * 8000000);
    $display("linear_diophantine_range_count regression: fail");
    $finish;
  end

endmodule
